/* src/assert_macros.svh */
// Assertion macros used by the port-level checker of the equalizer.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication on the next edge, checked through reset as well.
`define ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/mbeq_pkg.sv */
// Shared constants, types and command codes of the three-band biquad equalizer.
// No dependencies.
package mbeq_pkg;

  localparam int CHANNELS    = 16;
  localparam int BANDS       = 3;
  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 26;
  localparam int NCOEF       = 5;
  localparam int NHIST       = 4;
  localparam int COEFF_FRAC  = COEFF_BITS - 4;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CA_W   = $clog2(CHANNELS * NCOEF);
  localparam int HA_W   = CH_W + 2;
  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + 4;

  // action codes
  localparam logic [1:0] ACT_FILTER = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // coefficient slots
  localparam logic [2:0] IDX_B0 = 3'd0;
  localparam logic [2:0] IDX_B1 = 3'd1;
  localparam logic [2:0] IDX_B2 = 3'd2;
  localparam logic [2:0] IDX_A1 = 3'd3;
  localparam logic [2:0] IDX_A2 = 3'd4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEFF_BITS-1:0]  coeff_t;

  localparam coeff_t COEFF_ONE = coeff_t'(1 << COEFF_FRAC);

  // coefficient load / history clear command to one band cell
  typedef struct packed {
    logic            load;
    logic            clear;
    logic [CH_W-1:0] ch;
    logic [2:0]      idx;
    coeff_t          value;
  } cell_cmd_t;

endpackage

/* src/mbeq_cell.sv */
// One biquad band cell: per-channel coefficients and history, one shared multiplier.
// Depends on mbeq_pkg.
module mbeq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  mbeq_pkg::sample_t         x_in,
  input  logic [mbeq_pkg::CH_W-1:0] ch,
  input  mbeq_pkg::cell_cmd_t       cmd,
  output logic                      done,
  output mbeq_pkg::sample_t         y_out
);
  import mbeq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;
  localparam logic [2:0] MAC_LAST = 3'd7;
  localparam logic [2:0] WB_LAST  = 3'd3;

  logic [1:0] state;
  logic [2:0] cnt;

  coeff_t  cmem [CHANNELS*NCOEF];
  sample_t hmem [CHANNELS*NHIST];
  logic [CHANNELS*NCOEF-1:0] cval;
  logic [CHANNELS-1:0]       hval;

  sample_t x, x1, y1;
  coeff_t  c_rd;
  sample_t h_rd;
  logic    c_ok, h_ok, rd_v, p_v, p_neg;
  logic [2:0] rd_i;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic [CA_W-1:0] c_addr, c_waddr;
  logic [HA_W-1:0] h_addr, h_waddr;
  logic            issue;
  coeff_t          coef_eff;
  sample_t         opnd, wb_data;
  logic signed [ACC_W-1:0] rnd, shr;
  sample_t         y_sat;

  // read addresses: term cnt uses coefficient cnt and history entry cnt-1
  assign issue   = (state == ST_MAC) && (int'(cnt) < NCOEF);
  assign c_addr  = CA_W'(int'(ch) * NCOEF + int'(cnt));
  assign h_addr  = {ch, 2'(cnt - 3'd1)};
  assign c_waddr = CA_W'(int'(cmd.ch) * NCOEF + int'(cmd.idx));
  assign h_waddr = {ch, cnt[1:0]};

  // coefficient memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmem[c_waddr] <= cmd.value;
    end
    c_rd <= cmem[c_addr];
  end

  // history memory: x1, x2, y1, y2 per channel
  always_ff @(posedge clk) begin
    if (state == ST_WB) begin
      hmem[h_waddr] <= wb_data;
    end
    h_rd <= hmem[h_addr];
  end

  // never-written entries read as reset values
  always_comb begin
    coef_eff = c_ok ? c_rd : ((rd_i == IDX_B0) ? COEFF_ONE : '0);
    opnd     = (rd_i == IDX_B0) ? x : (h_ok ? h_rd : '0);
  end

  // multiply stage, keeps x1 and y1 for the history shift
  always_ff @(posedge clk) begin
    prod  <= PROD_W'(coef_eff * opnd);
    p_neg <= (rd_i == IDX_A1) || (rd_i == IDX_A2);
    if (rd_v && rd_i == IDX_B1) begin
      x1 <= opnd;
    end
    if (rd_v && rd_i == IDX_A1) begin
      y1 <= opnd;
    end
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (p_v) begin
      acc <= p_neg ? acc - ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd = acc + (ACC_W'(1) <<< (COEFF_FRAC - 1));
    shr = rnd >>> COEFF_FRAC;
    if (shr > ACC_W'(2 ** (SAMPLE_BITS - 1) - 1)) begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (shr < -(ACC_W'(2 ** (SAMPLE_BITS - 1)))) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = shr[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    wb_data = x;
      2'd1:    wb_data = x1;
      2'd2:    wb_data = y_out;
      default: wb_data = y1;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      x <= x_in;
    end
    if (state == ST_MAC && cnt == MAC_LAST) begin
      y_out <= y_sat;
    end
  end

  // sequencer and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      cval  <= '0;
      hval  <= '0;
      rd_v  <= 1'b0;
      p_v   <= 1'b0;
      done  <= 1'b0;
      rd_i  <= '0;
      c_ok  <= 1'b0;
      h_ok  <= 1'b0;
    end else begin
      done <= (state == ST_WB) && (cnt == WB_LAST);
      rd_v <= issue;
      p_v  <= rd_v;
      rd_i <= cnt;
      c_ok <= cval[c_addr];
      h_ok <= hval[ch];
      if (cmd.load) begin
        cval[c_waddr] <= 1'b1;
      end
      if (cmd.clear) begin
        hval[cmd.ch] <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MAC;
            cnt   <= '0;
          end
        end
        ST_MAC: begin
          if (cnt == MAC_LAST) begin
            state <= ST_WB;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_WB: begin
          if (cnt == WB_LAST) begin
            state    <= ST_IDLE;
            cnt      <= '0;
            hval[ch] <= 1'b1;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/multichannel_three_band_biquad_eq.sv */
// Top level of the 16-channel three-band biquad equalizer: command decode,
// band cell chain and output register. Depends on mbeq_pkg and mbeq_cell.
//
//  channel | handshake           | beat fields
//  --------+---------------------+------------------------------------------------
//  input   | in_valid / in_stall | action channel band coeff_index coeff_value sample_in
//  output  | out_valid/out_stall | sample_out out_channel
//
// A sample beat passes through the band cells in turn; each multiplies and accumulates,
// writes back its history and starts the next; the last cell's result goes to y_hold,
// then into the output register once that is free. The input stalls until then.
// Load and clear beats leave in_stall low. Each cell's single multiplier sets the rate.
// Reset sets every coefficient set to pass-through and all history to zero at once.
// A result waiting on out_stall does not block new beats; the next result waits for it.
module multichannel_three_band_biquad_eq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [3:0]          channel,
  input  logic [1:0]          band,
  input  logic [2:0]          coeff_index,
  input  mbeq_pkg::coeff_t    coeff_value,
  input  mbeq_pkg::sample_t   sample_in,
  output logic                out_valid,
  input  logic                out_stall,
  output mbeq_pkg::sample_t   sample_out,
  output logic [3:0]          out_channel
);
  import mbeq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic [3:0] ch_reg;
  sample_t    y_hold;
  logic       accept, ch_ok, idx_ok, start, out_free;

  logic      done_c [BANDS];
  sample_t   y_c    [BANDS];
  cell_cmd_t cmd_c  [BANDS];

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ch_ok    = int'(channel) < CHANNELS;
  assign idx_ok   = int'(coeff_index) < NCOEF;
  assign start    = accept && (action == ACT_FILTER) && ch_ok;
  assign out_free = !out_valid || !out_stall;

  // band cells, each feeding the next
  for (genvar k = 0; k < BANDS; k++) begin : g_band
    always_comb begin
      cmd_c[k].load  = accept && (action == ACT_LOAD) && ch_ok && idx_ok
                       && (int'(band) == k);
      cmd_c[k].clear = accept && (action == ACT_CLEAR) && ch_ok;
      cmd_c[k].ch    = CH_W'(channel);
      cmd_c[k].idx   = coeff_index;
      cmd_c[k].value = coeff_value;
    end

    if (k == 0) begin : g_head
      mbeq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .start (start),
        .x_in  (sample_in),
        .ch    (CH_W'(ch_reg)),
        .cmd   (cmd_c[k]),
        .done  (done_c[k]),
        .y_out (y_c[k])
      );
    end else begin : g_link
      mbeq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .start (done_c[k-1]),
        .x_in  (y_c[k-1]),
        .ch    (CH_W'(ch_reg)),
        .cmd   (cmd_c[k]),
        .done  (done_c[k]),
        .y_out (y_c[k])
      );
    end
  end

  // sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && action == ACT_FILTER) begin
            state <= ch_ok ? ST_RUN : ST_HOLD;
          end
        end
        ST_RUN: begin
          if (done_c[BANDS-1]) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && action == ACT_FILTER) begin
      ch_reg <= channel;
      y_hold <= sample_in;
    end
    if (state == ST_RUN && done_c[BANDS-1]) begin
      y_hold <= y_c[BANDS-1];
    end
    if (state == ST_HOLD && out_free) begin
      sample_out  <= y_hold;
      out_channel <= ch_reg;
    end
  end

endmodule

/* src/mbeq_checker.sv */
// Port-level checker for the equalizer top level, bound to it below.
// Depends on mbeq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbeq_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        action,
  input logic              out_valid,
  input logic              out_stall,
  input mbeq_pkg::sample_t sample_out,
  input logic [3:0]        out_channel
);
  import mbeq_pkg::*;

  // a held result keeps its beat
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sample_out) && $stable(out_channel), "held result changed")

  // load, clear and unused-code beats leave the input open
  `ASSERT_NEXT(a_cmd_quick, clk, rst, in_valid && !in_stall && action != ACT_FILTER, !in_stall, "command beat blocked input")

  // a sample beat keeps the input busy while it is filtered
  `ASSERT_NEXT(a_sample_busy, clk, rst, in_valid && !in_stall && action == ACT_FILTER, in_stall, "input open during filtering")

  // reset leaves no result pending
  `ASSERT_NEXT_NORST(a_rst_empty, clk, rst, !out_valid && !in_stall, "state after reset")

endmodule

bind multichannel_three_band_biquad_eq mbeq_checker u_mbeq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .action      (action),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .sample_out  (sample_out),
  .out_channel (out_channel)
);

/* tb/tb_multichannel_three_band_biquad_eq.sv */
// Testbench for the 16-channel three-band biquad equalizer: directed and random beats,
// checked against an in-bench predictor of the cascaded direct-form-1 filters.
// Depends on mbeq_pkg and multichannel_three_band_biquad_eq.
`timescale 1ns / 1ps

module tb_multichannel_three_band_biquad_eq;
  import mbeq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_FILTER;
  logic [3:0]  channel = '0;
  logic [1:0]  band = '0;
  logic [2:0]  coeff_index = IDX_B0;
  coeff_t      coeff_value = '0;
  sample_t     sample_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sample_t     sample_out;
  logic [3:0]  out_channel;

  typedef struct packed {
    sample_t    smp;
    logic [3:0] ch;
  } eq_result_t;

  // predictor state: coefficients [ch][band][idx], history [ch][band] x1 x2 y1 y2
  logic signed [63:0] eq_coeff [CHANNELS][BANDS][NCOEF];
  logic signed [63:0] eq_hist  [CHANNELS][BANDS][NHIST];
  eq_result_t expected_q[$];

  int  n_errors = 0;
  int  n_checked = 0;
  int  n_sent = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  stall_enable = 1'b1;

  multichannel_three_band_biquad_eq i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .channel(channel), .band(band),
    .coeff_index(coeff_index), .coeff_value(coeff_value), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_out(sample_out), .out_channel(out_channel)
  );

  always #5 clk = ~clk;

  // predictor reset: pass-through coefficients, cleared history
  function automatic void eq_model_reset();
    for (int c = 0; c < CHANNELS; c++)
      for (int b = 0; b < BANDS; b++) begin
        for (int k = 0; k < NCOEF; k++)
          eq_coeff[c][b][k] = (k == IDX_B0) ? 64'sd1 <<< COEFF_FRAC : 64'sd0;
        for (int k = 0; k < NHIST; k++)
          eq_hist[c][b][k] = 64'sd0;
      end
  endfunction

  // one biquad stage; rounds half up, saturates
  function automatic logic signed [63:0] biquad_stage(int c, int b, logic signed [63:0] x);
    logic signed [63:0] acc;
    logic signed [63:0] y;
    acc = eq_coeff[c][b][0] * x + eq_coeff[c][b][1] * eq_hist[c][b][0]
        + eq_coeff[c][b][2] * eq_hist[c][b][1] - eq_coeff[c][b][3] * eq_hist[c][b][2]
        - eq_coeff[c][b][4] * eq_hist[c][b][3] + (64'sd1 <<< (COEFF_FRAC - 1));
    y = acc >>> COEFF_FRAC;
    if (y > 64'sd8388607) y = 64'sd8388607;
    if (y < -64'sd8388608) y = -64'sd8388608;
    eq_hist[c][b][1] = eq_hist[c][b][0];
    eq_hist[c][b][0] = x;
    eq_hist[c][b][3] = eq_hist[c][b][2];
    eq_hist[c][b][2] = y;
    return y;
  endfunction

  // apply one accepted beat to the predictor
  function automatic void eq_predict(logic [1:0] act, logic [3:0] ch, logic [1:0] bnd,
                                     logic [2:0] idx, coeff_t cv, sample_t si);
    logic signed [63:0] x;
    eq_result_t r;
    x = 64'(si);
    case (act)
      ACT_FILTER: begin
        if (ch < CHANNELS)
          for (int b = 0; b < BANDS; b++) x = biquad_stage(int'(ch), b, x);
        r.smp = sample_t'(x);
        r.ch  = ch;
        expected_q.push_back(r);
      end
      ACT_LOAD: begin
        if (ch < CHANNELS && bnd < BANDS && idx <= IDX_A2)
          eq_coeff[ch][bnd][idx] = 64'(cv);
      end
      ACT_CLEAR: begin
        if (ch < CHANNELS)
          for (int b = 0; b < BANDS; b++)
            for (int k = 0; k < NHIST; k++) eq_hist[ch][b][k] = 64'sd0;
      end
      default: ;
    endcase
  endfunction

  // send one beat; idle gap first if one is given, then hold until accepted
  task automatic send_beat(logic [1:0] act, logic [3:0] ch, logic [1:0] bnd,
                           logic [2:0] idx, coeff_t cv, sample_t si, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    channel     <= ch;
    band        <= bnd;
    coeff_index <= idx;
    coeff_value <= cv;
    sample_in   <= si;
    do @(posedge clk); while (in_stall);
    eq_predict(act, ch, bnd, idx, cv, si);
    n_sent++;
  endtask

  // drop valid after the last beat of a sequence
  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_sample(logic [3:0] ch, sample_t si, int gap = 0);
    send_beat(ACT_FILTER, ch, 2'($urandom), 3'($urandom), coeff_t'($urandom), si, gap);
  endtask

  task automatic load_coeff(logic [3:0] ch, logic [1:0] bnd, logic [2:0] idx, coeff_t cv);
    send_beat(ACT_LOAD, ch, bnd, idx, cv, sample_t'($urandom), 0);
  endtask

  task automatic wait_drained();
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random coefficient in a mild range, or anywhere in the field
  function automatic coeff_t rand_coeff(bit wild);
    if (wild) return coeff_t'($urandom);
    return coeff_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
  endfunction

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    eq_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: sample_out %0d out_channel %0d",
               sample_out, out_channel);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (sample_out !== e.smp) begin
          $error("sample_out expected %0d actual %0d", e.smp, sample_out);
          n_errors++;
        end
        if (out_channel !== e.ch) begin
          $error("out_channel expected %0d actual %0d", e.ch, out_channel);
          n_errors++;
        end
      end
    end
  end

  // receiver stall pattern, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (!stall_enable) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // watchdog: cycles with no accepted beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
      idle_cycles <= 0;
    else if (in_valid || expected_q.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_multichannel_three_band_biquad_eq: errors");
      $finish;
    end
  end

  // pass-through after reset, field extremes, unused action code
  task automatic test_passthrough();
    send_sample(4'd0, 24'sh7FFFFF);
    send_sample(4'd15, 24'sh800000);
    send_sample(4'd3, 24'sh000000);
    send_sample(4'd7, 24'shFFFFFF);
    send_beat(ACT_UNUSED, 4'd5, 2'd3, 3'd7, 26'sh3FFFFFF, 24'sh555555, 0);
    send_sample(4'd5, 24'sh2AAAAA);
    wait_drained();
  endtask

  // loads incl. out-of-range band/index, extreme coefficients, saturation, clear
  task automatic test_loads_and_clear();
    load_coeff(4'd1, 2'd0, IDX_B0, 26'sh1FFFFFF);
    load_coeff(4'd1, 2'd1, IDX_B1, 26'sh2000000);
    load_coeff(4'd1, 2'd2, IDX_A1, rand_coeff(1'b0));
    load_coeff(4'd1, 2'd2, IDX_A2, rand_coeff(1'b0));
    load_coeff(4'd1, 2'd0, IDX_B2, rand_coeff(1'b0));
    load_coeff(4'd1, 2'd3, IDX_B0, 26'sh0000001);
    load_coeff(4'd1, 2'd0, 3'd5, 26'sh0000001);
    load_coeff(4'd1, 2'd0, 3'd7, 26'sh0000001);
    send_sample(4'd1, 24'sh7FFFFF);
    send_sample(4'd1, 24'sh800000);
    send_sample(4'd1, 24'sh012345);
    send_beat(ACT_CLEAR, 4'd1, 2'd0, IDX_B0, '0, '0, 0);
    send_sample(4'd1, 24'sh000001);
    send_beat(ACT_CLEAR, 4'd15, 2'd2, IDX_A2, '0, '0, 0);
    send_sample(4'd15, 24'sh400000);
    wait_drained();
  endtask

  // random traffic: sample streams with occasional loads, clears and unused action codes
  task automatic test_random(int n_items);
    int burst;
    int gap;
    int r;
    burst = 0;
    for (int i = 0; i < n_items; i++) begin
      gap = 0;
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 60);
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_sample(4'($urandom), sample_t'($urandom), gap);
      end else if (r < 93) begin
        send_beat(ACT_LOAD, 4'($urandom), 2'($urandom), 3'($urandom),
                  rand_coeff($urandom_range(0, 9) == 0), sample_t'($urandom), gap);
      end else if (r < 98) begin
        send_beat(ACT_CLEAR, 4'($urandom), 2'($urandom), 3'($urandom),
                  coeff_t'($urandom), sample_t'($urandom), gap);
      end else begin
        send_beat(ACT_UNUSED, 4'($urandom), 2'($urandom), 3'($urandom),
                  coeff_t'($urandom), sample_t'($urandom), gap);
      end
      // no stalls for a stretch now and then
      if (i % 200 == 100) stall_enable = ~stall_enable;
    end
    stall_enable = 1'b1;
    wait_drained();
  endtask

  // receiver holds off long while samples keep coming; input must back up
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) send_sample(4'($urandom), sample_t'($urandom));
        idle_input();
      end
    join
    wait_drained();
  endtask

  initial begin
    eq_model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_passthrough();
    test_loads_and_clear();
    test_backpressure();
    test_random(1000);
    $display("Run covered %0d input beats and %0d checked result beats,", n_sent, n_checked);
    $display("including loads, clears, unused codes, saturation and a long output hold-off.");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("tb_multichannel_three_band_biquad_eq: clean");
    end else begin
      if (expected_q.size() != 0)
        $error("%0d expected results never arrived", expected_q.size());
      $display("tb_multichannel_three_band_biquad_eq: errors");
    end
    $finish;
  end

endmodule
